>>> design/xpfe_pkg.sv
package xpfe_pkg;

   // Input transaction: one command with its operands
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic        pkt_end;
      logic [31:0] seq_base;
      logic [15:0] selection;
   } req_type;

   // Result transaction: one per input transaction
   typedef struct packed {
      logic [1:0] status;
      logic       byte_valid;
      logic [7:0] frame_byte;
      logic       frame_last;
   } rsp_type;

   // Commands
   localparam logic [1:0] CMD_ABSORB = 2'd0;
   localparam logic [1:0] CMD_CLOSE  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_DROPPED  = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // Register map (index = paddr[3:2])
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_START_OFFSET = 2'd0;
   localparam logic [1:0] REG_STOP_OFFSET  = 2'd1;
   localparam logic [1:0] REG_FRAME_TAG    = 2'd2;

   localparam logic [15:0] START_OFFSET_RESET = 16'd4;
   localparam logic [15:0] STOP_OFFSET_RESET  = 16'd16;
   localparam logic [15:0] FRAME_TAG_RESET    = 16'd0;

   // Frame layout: start (4), tag (2), parity, stop (4), selection (2)
   localparam int unsigned HEAD_BYTES = 6;
   localparam int unsigned TAIL_BYTES = 6;

   // Big-endian byte i of a 32-bit word
   function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = word[31:24];
         2'd1: b = word[23:16];
         2'd2: b = word[15:8];
         default: b = word[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> design/xpfe_ram.sv
module xpfe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/xor_parity_frame_encoder_unit.sv
// XOR parity frame encoder. Absorb transactions XOR packet bytes into a parity
// memory at their offset in the packet; a close transaction freezes the range
// and parity length and opens a new range; read transactions then return the
// frame (start, tag, parity bytes, stop, selection, big-endian) one byte each,
// clearing parity bytes as they go. The block takes one transaction per clock
// while the result channel is not stalled, and returns its result through a memory
// stage and an output register, so a stalled result does not stop the next
// transaction from entering the memory stage. The single parity memory does one
// read per transaction at acceptance and one write when it leaves the memory stage,
// with the last write forwarded to a read of the same entry. Parity entries never
// written since reset read as zero through a high-water mark, so there is no
// clearing pass and the block is ready right after reset.
module xor_parity_frame_encoder_unit #(
   parameter int unsigned MAX_LEN = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  xpfe_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output xpfe_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [xpfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   import xpfe_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_LEN);
   localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
   localparam int unsigned POS_W  = $clog2(MAX_LEN + HEAD_BYTES + TAIL_BYTES + 1);

   // Memory stage carried from acceptance to the result register
   typedef struct packed {
      logic [1:0]        status;
      logic              byte_valid;
      logic              frame_last;
      logic              use_mem;
      logic              clear;
      logic              zero;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } stage_type;

   // ---------------- registers ----------------
   logic [15:0] start_offset_ff, stop_offset_ff, frame_tag_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= START_OFFSET_RESET;
         stop_offset_ff  <= STOP_OFFSET_RESET;
         frame_tag_ff    <= FRAME_TAG_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_START_OFFSET: start_offset_ff <= pwdata[15:0];
            REG_STOP_OFFSET:  stop_offset_ff  <= pwdata[15:0];
            REG_FRAME_TAG:    frame_tag_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_START_OFFSET: prdata = {16'd0, start_offset_ff};
         REG_STOP_OFFSET:  prdata = {16'd0, stop_offset_ff};
         REG_FRAME_TAG:    prdata = {16'd0, frame_tag_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ---------------- control state ----------------
   logic [LEN_W-1:0] byte_offset_ff, byte_offset_in;
   logic [LEN_W-1:0] parity_length_ff, parity_length_in;
   logic [LEN_W-1:0] high_water_ff, high_water_in;
   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [POS_W-1:0] read_position_ff, read_position_in;
   logic             pending_ff, pending_in;
   logic [31:0]      range_start_ff, range_start_in;
   logic [31:0]      range_stop_ff, range_stop_in;
   logic [31:0]      frame_start_ff, frame_start_in;
   logic [31:0]      frame_stop_ff, frame_stop_in;
   logic [15:0]      frame_selection_ff, frame_selection_in;

   logic             stage_valid_ff;
   stage_type        stage_ff, stage_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]       fwd_data_ff;

   logic             stage_adv, accept;
   logic [POS_W-1:0] body_end, pos_next, tail_pos, body_pos;
   logic [LEN_W-1:0] offset_next, longest;
   logic [LEN_W-1:0] rd_addr_ext;

   assign stage_adv = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || stage_adv;
   assign accept    = req_valid && req_ready;

   assign body_end = POS_W'(HEAD_BYTES) + POS_W'(frame_length_ff);
   assign pos_next = read_position_ff + POS_W'(1);
   assign tail_pos = read_position_ff - body_end;
   assign body_pos = read_position_ff - POS_W'(HEAD_BYTES);

   // Decode one transaction: next control state and memory stage contents
   always_comb begin
      byte_offset_in     = byte_offset_ff;
      parity_length_in   = parity_length_ff;
      high_water_in      = high_water_ff;
      frame_length_in    = frame_length_ff;
      read_position_in   = read_position_ff;
      pending_in         = pending_ff;
      range_start_in     = range_start_ff;
      range_stop_in      = range_stop_ff;
      frame_start_in     = frame_start_ff;
      frame_stop_in      = frame_stop_ff;
      frame_selection_in = frame_selection_ff;
      offset_next        = byte_offset_ff;
      longest            = parity_length_ff;
      rd_addr_ext        = '0;
      stage_in           = '0;

      unique case (req_data.cmd)
         CMD_ABSORB: begin
            if (pending_ff) begin
               stage_in.status = ST_REJECTED;
            end else begin
               if (byte_offset_ff < LEN_W'(MAX_LEN)) begin
                  offset_next      = byte_offset_ff + LEN_W'(1);
                  stage_in.use_mem = 1'b1;
                  stage_in.addr    = byte_offset_ff[ADDR_W-1:0];
                  stage_in.data    = req_data.data_byte;
                  stage_in.zero    = (byte_offset_ff >= high_water_ff);
                  if (byte_offset_ff >= high_water_ff) begin
                     high_water_in = offset_next;
                  end
               end else begin
                  stage_in.status = ST_DROPPED;
               end
               byte_offset_in = offset_next;
               if (req_data.pkt_end) begin
                  if (parity_length_ff < offset_next) begin
                     parity_length_in = offset_next;
                  end
                  byte_offset_in = '0;
               end
            end
         end
         CMD_CLOSE: begin
            if (pending_ff) begin
               stage_in.status = ST_REJECTED;
            end else begin
               if (byte_offset_ff > parity_length_ff) begin
                  longest = byte_offset_ff;
               end
               frame_start_in     = range_start_ff;
               frame_stop_in      = range_stop_ff;
               frame_selection_in = req_data.selection;
               frame_length_in    = longest;
               read_position_in   = '0;
               pending_in         = 1'b1;
               range_start_in     = req_data.seq_base + {16'd0, start_offset_ff};
               range_stop_in      = req_data.seq_base + {16'd0, stop_offset_ff};
               parity_length_in   = '0;
               byte_offset_in     = '0;
            end
         end
         CMD_READ: begin
            if (!pending_ff) begin
               stage_in.status = ST_EMPTY;
            end else begin
               stage_in.byte_valid = 1'b1;
               if (read_position_ff < POS_W'(4)) begin
                  stage_in.data = be_byte(frame_start_ff, read_position_ff[1:0]);
               end else if (read_position_ff < POS_W'(HEAD_BYTES)) begin
                  stage_in.data = read_position_ff[0] ? frame_tag_ff[7:0]
                                                      : frame_tag_ff[15:8];
               end else if (read_position_ff < body_end) begin
                  // parity byte: read and clear
                  stage_in.use_mem = 1'b1;
                  stage_in.clear   = 1'b1;
                  stage_in.addr    = body_pos[ADDR_W-1:0];
                  rd_addr_ext      = LEN_W'(body_pos[ADDR_W-1:0]);
                  stage_in.zero    = (rd_addr_ext >= high_water_ff);
               end else if (tail_pos < POS_W'(4)) begin
                  stage_in.data = be_byte(frame_stop_ff, tail_pos[1:0]);
               end else begin
                  stage_in.data = tail_pos[0] ? frame_selection_ff[7:0]
                                              : frame_selection_ff[15:8];
               end
               if (pos_next >= body_end + POS_W'(TAIL_BYTES)) begin
                  stage_in.frame_last = 1'b1;
                  pending_in          = 1'b0;
                  read_position_in    = '0;
               end else begin
                  read_position_in = pos_next;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff     <= '0;
         parity_length_ff   <= '0;
         high_water_ff      <= '0;
         frame_length_ff    <= '0;
         read_position_ff   <= '0;
         pending_ff         <= 1'b0;
         range_start_ff     <= '0;
         range_stop_ff      <= '0;
         frame_start_ff     <= '0;
         frame_stop_ff      <= '0;
         frame_selection_ff <= '0;
      end else if (accept) begin
         byte_offset_ff     <= byte_offset_in;
         parity_length_ff   <= parity_length_in;
         high_water_ff      <= high_water_in;
         frame_length_ff    <= frame_length_in;
         read_position_ff   <= read_position_in;
         pending_ff         <= pending_in;
         range_start_ff     <= range_start_in;
         range_stop_ff      <= range_stop_in;
         frame_start_ff     <= frame_start_in;
         frame_stop_ff      <= frame_stop_in;
         frame_selection_ff <= frame_selection_in;
      end
   end

   // ---------------- parity memory ----------------
   logic        mem_wr;
   logic [7:0]  mem_rdata, mem_byte, mem_wdata;

   assign mem_wr = stage_adv && stage_ff.use_mem;

   xpfe_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEN)
   ) u_parity_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (stage_ff.addr),
      .wr_data (mem_wdata),
      .rd_en   (accept && stage_in.use_mem),
      .rd_addr (stage_in.addr),
      .rd_data (mem_rdata)
   );

   // Entry at or above the high-water mark is still zero; last write is forwarded
   always_comb begin
      if (stage_ff.zero) begin
         mem_byte = 8'd0;
      end else if (fwd_valid_ff && (fwd_addr_ff == stage_ff.addr)) begin
         mem_byte = fwd_data_ff;
      end else begin
         mem_byte = mem_rdata;
      end
      mem_wdata = stage_ff.clear ? 8'd0 : (mem_byte ^ stage_ff.data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (mem_wr) begin
         fwd_valid_ff <= 1'b1;
      end
      if (mem_wr) begin
         fwd_addr_ff <= stage_ff.addr;
         fwd_data_ff <= mem_wdata;
      end
   end

   // ---------------- memory stage and result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= accept;
         end
         if (stage_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
      if (stage_adv) begin
         rsp_data_ff.status     <= stage_ff.status;
         rsp_data_ff.byte_valid <= stage_ff.byte_valid;
         rsp_data_ff.frame_last <= stage_ff.frame_last;
         rsp_data_ff.frame_byte <= stage_ff.clear ? mem_byte
                                 : (stage_ff.use_mem ? 8'd0 : stage_ff.data);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/xpfe_checker.sv
module xpfe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input xpfe_pkg::rsp_type rsp_data
);

   import xpfe_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A frame byte only comes with ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |-> rsp_data.status == ST_OK)
      else $error("frame byte with error status");

   // Without a frame byte, byte and last flag are zero
   a_no_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.frame_byte == 8'd0
                                             && !rsp_data.frame_last)
      else $error("stray frame byte or last flag");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A new result needs reset low and req_ready high in the previous cycle
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset) && $past(req_ready))
      else $error("result without accepted transaction");

endmodule

bind xor_parity_frame_encoder_unit xpfe_checker u_xpfe_checker (.*);
